@@ sv/kms_pkg.sv @@
// Package for the key matrix MIDI note scanner.
// Holds register indexes, reset values, MIDI constants and the shared structs.
// No dependencies.
package kms_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int KEYS       = 16;
    localparam int POS_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER_CHAN = 2'd0,
        CFG_LOWER_CHAN = 2'd1,
        CFG_BASE_NOTE  = 2'd2,
        CFG_VELOCITY   = 2'd3
    } t_cfg_idx;

    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [6:0] NOTE_MAX     = 7'd127;

    localparam logic [3:0] RST_UPPER_CHAN = 4'd12;
    localparam logic [3:0] RST_LOWER_CHAN = 4'd11;
    localparam logic [6:0] RST_BASE_NOTE  = 7'd36;
    localparam logic [6:0] RST_VELOCITY   = 7'd64;

    typedef struct packed {
        logic [3:0] upper_chan;
        logic [3:0] lower_chan;
        logic [6:0] base_note;
        logic [6:0] velocity;
    } t_cfg;

    // One column's worth of work: changed keys in emission order.
    typedef struct packed {
        logic [3:0]      chan;
        logic [7:0]      offset;
        logic [KEYS-1:0] mask;
        logic [KEYS-1:0] press;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ sv/kms_if.sv @@
// Channel interfaces for the key matrix MIDI note scanner.
// Depends on kms_pkg for the configuration port widths.
interface kms_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] column;
    logic [7:0] left_keys;
    logic [7:0] right_keys;
    modport source (output valid, column, left_keys, right_keys, input ready);
    modport sink   (input valid, column, left_keys, right_keys, output ready);
endinterface

interface kms_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       last_event;
    modport source (output valid, status_byte, note, velocity, last_event, input ready);
    modport sink   (input valid, status_byte, note, velocity, last_event, output ready);
endinterface

interface kms_cfg_if import kms_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/key_matrix_midi_note_scanner.sv @@
// Top level of the key matrix MIDI note scanner: configuration registers,
// front end, command queue and back end. Depends on kms_pkg, kms_if and the kms_* modules.
//
// Each accepted input transaction is one scanned matrix column with two key bytes.
// Keys that differ from the stored state of that column each produce one MIDI
// note event (note-on or note-off), left keys bit 0 upward then right keys
// bit 7 downward; last_event marks the final event of a column. A column with
// no change, or beyond NUM_COLUMNS, produces nothing. The front end takes a
// column every cycle while the two-entry command queue has room; the back end
// emits one event per changed key (1 to 16), one per cycle while the output
// is not stalled, and so sets the sustained rate. Events pass through the queue,
// the back-end mask register and the output register. Key state resets to all keys up.
module key_matrix_midi_note_scanner import kms_pkg::*; #(
    parameter int NUM_COLUMNS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kms_in_if.sink     i_in,
    kms_out_if.source  o_out,
    kms_cfg_if.sink    i_cfg
);
    t_cfg      r_cfg;
    t_cmd      w_front_cmd;
    t_cmd      w_head_cmd;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper_chan <= RST_UPPER_CHAN;
            r_cfg.lower_chan <= RST_LOWER_CHAN;
            r_cfg.base_note  <= RST_BASE_NOTE;
            r_cfg.velocity   <= RST_VELOCITY;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_UPPER_CHAN: r_cfg.upper_chan <= i_cfg.data[3:0];
                CFG_LOWER_CHAN: r_cfg.lower_chan <= i_cfg.data[3:0];
                CFG_BASE_NOTE:  r_cfg.base_note  <= i_cfg.data[6:0];
                CFG_VELOCITY:   r_cfg.velocity   <= i_cfg.data[6:0];
                default: ;
            endcase
        end
    end

    kms_front #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    kms_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    kms_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_head_cmd),
        .i_q_status (w_q_status),
        .i_velocity (r_cfg.velocity),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("command pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("command popped from empty queue");

    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status_byte[7:4] == NIB_NOTE_ON ||
                         o_out.status_byte[7:4] == NIB_NOTE_OFF))
        else $error("status byte is neither note-on nor note-off");

    a_out_of_range_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (32'(i_in.column) >= NUM_COLUMNS)) |-> !w_push)
        else $error("out-of-range column queued events");

endmodule

@@ sv/kms_front.sv @@
// Front end: accepts scanned columns, diffs them against the stored key state
// and queues the changed keys in emission order. Depends on kms_pkg, kms_if.
module kms_front import kms_pkg::*; #(
    parameter int NUM_COLUMNS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kms_in_if.sink     i_in,
    input  t_cfg       i_cfg,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_cmd       o_cmd
);
    localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    logic [KEYS-1:0] r_prev [NUM_COLUMNS];
    logic [KEYS-1:0] n_prev;

    logic [COL_W-1:0] w_idx;
    logic             w_in_range;
    logic             w_accept;
    logic [KEYS-1:0]  w_old;
    logic [7:0]       w_ldiff;
    logic [7:0]       w_rdiff;

    assign i_in.ready = !i_q_status.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_idx      = COL_W'(i_in.column);
    assign w_in_range = (32'(i_in.column) < NUM_COLUMNS);
    assign w_old      = w_in_range ? r_prev[w_idx] : '0;
    assign w_ldiff    = i_in.left_keys ^ w_old[7:0];
    assign w_rdiff    = i_in.right_keys ^ w_old[15:8];
    assign n_prev     = {i_in.right_keys, i_in.left_keys};

    // Left keys go out bit 0 upward, right keys bit 7 downward.
    always_comb begin
        o_cmd.chan   = i_in.column[2] ? i_cfg.lower_chan : i_cfg.upper_chan;
        o_cmd.offset = {1'b0, i_cfg.base_note} + 8'({i_in.column[1:0], 4'b0000});
        for (int p = 0; p < 8; p++) begin
            o_cmd.mask[p]      = w_ldiff[p];
            o_cmd.press[p]     = i_in.left_keys[p];
            o_cmd.mask[p + 8]  = w_rdiff[7 - p];
            o_cmd.press[p + 8] = i_in.right_keys[7 - p];
        end
    end

    assign o_push = w_accept && w_in_range && (|o_cmd.mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                r_prev[c] <= '0;
            end
        end else if (w_accept && w_in_range) begin
            r_prev[w_idx] <= n_prev;
        end
    end

endmodule

@@ sv/kms_fifo.sv @@
// Two-entry queue of column commands between the front and back ends.
// Depends on kms_pkg.
module kms_fifo import kms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);
    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_cmd           = r_mem[r_rd];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ sv/kms_back.sv @@
// Back end: walks a command's changed-key mask, one note event per cycle
// if not stalled, into an output register. Depends on kms_pkg, kms_if.
module kms_back import kms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_q_status i_q_status,
    input  logic [6:0] i_velocity,
    output logic      o_pop,
    kms_out_if.source o_out
);
    logic [KEYS-1:0] r_mask;
    logic [KEYS-1:0] r_press;
    logic [3:0]      r_chan;
    logic [7:0]      r_offset;

    logic       r_valid;
    logic [7:0] r_status;
    logic [6:0] r_note;
    logic [6:0] r_vel;
    logic       r_last;

    logic             w_busy;
    logic             w_emit;
    logic [POS_W-1:0] w_pos;
    logic [KEYS-1:0]  w_rest;
    logic             w_last;
    logic [7:0]       w_sum;
    logic [6:0]       w_note;
    logic [7:0]       w_status;

    assign w_busy = |r_mask;
    assign w_emit = w_busy && (!r_valid || o_out.ready);

    always_comb begin
        w_pos = '0;
        for (int p = KEYS - 1; p >= 0; p--) begin
            if (r_mask[p]) begin
                w_pos = POS_W'(p);
            end
        end
    end

    assign w_rest   = r_mask & ~(KEYS'(1) << w_pos);
    assign w_last   = (w_rest == '0);
    assign w_sum    = r_offset + 8'(w_pos);
    assign w_note   = (w_sum > 8'(NOTE_MAX)) ? NOTE_MAX : w_sum[6:0];
    assign w_status = {(r_press[w_pos] ? NIB_NOTE_ON : NIB_NOTE_OFF), r_chan};
    assign o_pop    = !i_q_status.empty && (!w_busy || (w_emit && w_last));

    assign o_out.valid       = r_valid;
    assign o_out.status_byte = r_status;
    assign o_out.note        = r_note;
    assign o_out.velocity    = r_vel;
    assign o_out.last_event  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mask <= i_cmd.mask;
            end else if (w_emit) begin
                r_mask <= w_rest;
            end
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_press  <= i_cmd.press;
            r_chan   <= i_cmd.chan;
            r_offset <= i_cmd.offset;
        end
        if (w_emit) begin
            r_status <= w_status;
            r_note   <= w_note;
            r_vel    <= i_velocity;
            r_last   <= w_last;
        end
    end

endmodule

@@ test/key_matrix_midi_note_scanner_test.sv @@
// Self-checking testbench for key_matrix_midi_note_scanner: scans columns, predicts
// the MIDI note events per changed key and checks them against the output channel.
// Depends on kms_pkg, kms_if and the scanner RTL.
module key_matrix_midi_note_scanner_test;
    import kms_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic [2:0] column;
        logic [7:0] left_keys;
        logic [7:0] right_keys;
    } t_scan;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] note;
        logic [6:0] velocity;
        logic       last_event;
    } t_note_event;

    logic i_clk;
    logic i_rst_n;

    kms_in_if  in_ch();
    kms_out_if out_ch();
    kms_cfg_if cfg_ch();

    key_matrix_midi_note_scanner #(.NUM_COLUMNS(8)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // stimulus side
    t_scan       scan_q[$];
    logic [15:0] sent_keys [8];
    int          in_gap;
    int          in_run;
    int          out_stall;
    int          out_run;

    // predictor side
    t_note_event expected_events[$];
    logic [15:0] prev_keys [8];
    logic [3:0]  chan_upper;
    logic [3:0]  chan_lower;
    logic [6:0]  base_note;
    logic [6:0]  note_vel;

    logic in_taken;
    logic out_taken;
    int   quiet_cycles;
    int   err_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Wait count per transaction; sometimes a run of back-to-back transactions.
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            run_left = $urandom_range(5, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (t_cfg_idx'(idx))
            CFG_UPPER_CHAN: chan_upper = value[3:0];
            CFG_LOWER_CHAN: chan_lower = value[3:0];
            CFG_BASE_NOTE:  base_note  = value[6:0];
            CFG_VELOCITY:   note_vel   = value[6:0];
            default: ;
        endcase
    endfunction

    // Left keys bit 0 upward, then right keys bit 7 downward; slot is the note position.
    function automatic void predict_column(input logic [2:0] col, input logic [7:0] left,
                                           input logic [7:0] right);
        logic [3:0]  chan;
        int          offset;
        int          bitpos;
        int          n_before;
        logic [15:0] now_keys;
        logic [15:0] changed;
        t_note_event ev;
        chan     = (col < 4) ? chan_upper : chan_lower;
        offset   = int'(base_note) + 16 * int'(col[1:0]);
        now_keys = {right, left};
        changed  = now_keys ^ prev_keys[col];
        n_before = expected_events.size();
        for (int slot = 0; slot < 16; slot++) begin
            bitpos = (slot < 8) ? slot : 23 - slot;
            if (changed[bitpos]) begin
                ev.status_byte = {now_keys[bitpos] ? NIB_NOTE_ON : NIB_NOTE_OFF, chan};
                ev.note        = (offset + slot > 127) ? NOTE_MAX : 7'(offset + slot);
                ev.velocity    = note_vel;
                ev.last_event  = 1'b0;
                expected_events.push_back(ev);
            end
        end
        if (expected_events.size() > n_before) begin
            ev = expected_events.pop_back();
            ev.last_event = 1'b1;
            expected_events.push_back(ev);
        end
        prev_keys[col] = now_keys;
    endfunction

    // Monitor: predict on accepted columns, check accepted events.
    always @(posedge i_clk) begin : monitor
        t_note_event got;
        t_note_event exp_ev;
        if (!i_rst_n) begin
            in_taken     <= 1'b0;
            out_taken    <= 1'b0;
            quiet_cycles <= 0;
            for (int c = 0; c < 8; c++) prev_keys[c] = '0;
            chan_upper = RST_UPPER_CHAN;
            chan_lower = RST_LOWER_CHAN;
            base_note  = RST_BASE_NOTE;
            note_vel   = RST_VELOCITY;
        end else begin
            in_taken  <= in_ch.valid && in_ch.ready;
            out_taken <= out_ch.valid && out_ch.ready;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (cfg_ch.valid && cfg_ch.ready)
                apply_register(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                predict_column(in_ch.column, in_ch.left_keys, in_ch.right_keys);
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.status_byte, out_ch.note, out_ch.velocity,
                       out_ch.last_event};
                if (expected_events.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected event: expected none, got %h/%0d/%0d/%0b",
                             $time, got.status_byte, got.note, got.velocity,
                             got.last_event);
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (got.status_byte !== exp_ev.status_byte || got.note !== exp_ev.note ||
                        got.velocity !== exp_ev.velocity ||
                        got.last_event !== exp_ev.last_event) begin
                        err_count++;
                        $display("%0t: event mismatch: expected %h/%0d/%0d/%0b, got %h/%0d/%0d/%0b",
                                 $time, exp_ev.status_byte, exp_ev.note, exp_ev.velocity,
                                 exp_ev.last_event, got.status_byte, got.note,
                                 got.velocity, got.last_event);
                    end
                end
            end
        end
    end

    // Column driver, fed from scan_q.
    always @(negedge i_clk) begin : drive_scans
        t_scan item;
        logic  nxt_valid;
        if (i_rst_n) begin
            nxt_valid = in_ch.valid;
            if (in_ch.valid && in_taken)
                nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (scan_q.size() > 0) begin
                    item = scan_q.pop_front();
                    in_ch.column     <= item.column;
                    in_ch.left_keys  <= item.left_keys;
                    in_ch.right_keys <= item.right_keys;
                    nxt_valid = 1'b1;
                    in_gap = draw_wait(in_run);
                end
            end
            in_ch.valid <= nxt_valid;
        end
    end

    // Event sink: stalls for a drawn number of cycles after each transaction.
    always @(negedge i_clk) begin : drive_ready
        if (i_rst_n) begin
            if (out_taken)
                out_stall = draw_wait(out_run);
            if (out_stall > 0) begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic queue_scan(input logic [2:0] col, input logic [7:0] left,
                              input logic [7:0] right);
        t_scan item;
        item.column     = col;
        item.left_keys  = left;
        item.right_keys = right;
        sent_keys[col]  = {right, left};
        scan_q.push_back(item);
    endtask

    // Mostly a few keys changing on top of the current column state, plus noise.
    task automatic queue_random_scan();
        logic [2:0]  col;
        logic [15:0] keys;
        int          kind;
        int          idx;
        col  = 3'($urandom_range(0, 7));
        keys = sent_keys[col];
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            repeat ($urandom_range(1, 3)) begin
                idx = $urandom_range(0, 15);
                keys[idx] = ~keys[idx];
            end
        end else if (kind < 8) begin
            keys = 16'($urandom);
        end else if (kind == 9) begin
            keys = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        end
        queue_scan(col, keys[7:0], keys[15:8]);
    endtask

    // Idle: nothing queued or in flight, then a wait that lets zero-event columns drain.
    task automatic wait_idle();
        while (!(scan_q.size() == 0 && !in_ch.valid && expected_events.size() == 0))
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] upper, input logic [7:0] lower,
                              input logic [7:0] base, input logic [7:0] vel);
        wait_idle();
        write_reg(CFG_UPPER_CHAN, upper);
        write_reg(CFG_LOWER_CHAN, lower);
        write_reg(CFG_BASE_NOTE, base);
        write_reg(CFG_VELOCITY, vel);
    endtask

    initial begin : stimulus
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.column     = '0;
        in_ch.left_keys  = '0;
        in_ch.right_keys = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_UPPER_CHAN;
        cfg_ch.data      = '0;
        in_gap    = 0;
        in_run    = 0;
        out_stall = 0;
        out_run   = 0;
        err_count = 0;
        for (int c = 0; c < 8; c++) sent_keys[c] = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration
        queue_scan(3'd0, 8'hFF, 8'hFF);     // all sixteen on
        queue_scan(3'd0, 8'hFF, 8'hFF);     // no change
        queue_scan(3'd0, 8'h00, 8'h00);     // all sixteen off
        queue_scan(3'd4, 8'h01, 8'h80);     // lower channel, edge keys
        queue_scan(3'd7, 8'h80, 8'h01);
        queue_scan(3'd3, 8'hAA, 8'h55);
        queue_scan(3'd3, 8'h55, 8'hAA);
        queue_scan(3'd1, 8'h00, 8'h00);
        queue_scan(3'd2, 8'h0F, 8'hF0);

        // top base note, notes pinned at the ceiling; stray high data bits ignored
        set_config(8'hF0, 8'hFF, 8'hFF, 8'h80);
        queue_scan(3'd3, 8'hFF, 8'hFF);
        queue_scan(3'd7, 8'hFF, 8'hFF);
        queue_scan(3'd0, 8'h01, 8'h00);
        queue_scan(3'd3, 8'h00, 8'h00);

        set_config(8'h0F, 8'h00, 8'h00, 8'h7F);
        queue_scan(3'd0, 8'h00, 8'hFF);
        queue_scan(3'd5, 8'hFF, 8'h00);
        queue_scan(3'd6, 8'h00, 8'hFF);
        queue_scan(3'd1, 8'hFF, 8'hFF);
        queue_scan(3'd4, 8'h00, 8'h00);

        // partial saturation inside one column
        set_config(8'd12, 8'd11, 8'd100, 8'd1);
        queue_scan(3'd1, 8'h00, 8'h00);
        queue_scan(3'd2, 8'hFF, 8'hFF);

        for (int phase = 0; phase < 4; phase++) begin
            set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            repeat (65) queue_random_scan();
        end

        wait_idle();
        repeat (12) @(posedge i_clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/kms_pkg.sv
sv/kms_if.sv
sv/kms_front.sv
sv/kms_fifo.sv
sv/kms_back.sv
sv/key_matrix_midi_note_scanner.sv
test/key_matrix_midi_note_scanner_test.sv
